// ----- hw/rtl/mgmt_frame_attack_detector_macros.svh -----
// Assertion macros for the management frame attack detector checker.
// Used by mfad_checker; needs clk and rst in scope where expanded.
`ifndef MGMT_FRAME_ATTACK_DETECTOR_MACROS_SVH
`define MGMT_FRAME_ATTACK_DETECTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define MFAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfad assertion failed");

// next-cycle implication, checked out of reset
`define MFAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfad assertion failed");

`endif

// ----- hw/rtl/mfad_pkg.sv -----
// Shared types, codes and reset values for the management frame attack detector.
// No dependencies.
package mfad_pkg;

  localparam int unsigned CHANNEL_COUNT = 13;

  localparam logic [15:0] MAX16 = 16'hFFFF;
  localparam logic [19:0] MAX20 = 20'hFFFFF;

  typedef enum logic [2:0] {
    ALERT_AMBIENT = 3'd0,
    ALERT_DEAUTH  = 3'd1,
    ALERT_BEACON  = 3'd2,
    ALERT_PROBE   = 3'd3,
    ALERT_MULTI   = 3'd4
  } alert_t;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] TYPE_MGMT     = 2'b00;
  localparam logic [3:0] SUB_DEAUTH    = 4'hC;
  localparam logic [3:0] SUB_DISASSOC  = 4'hA;
  localparam logic [3:0] SUB_PROBE     = 4'h4;
  localparam logic [3:0] SUB_BEACON    = 4'h8;

  localparam logic [2:0] REG_DEAUTH_LIMIT  = 3'd0;
  localparam logic [2:0] REG_PROBE_LIMIT   = 3'd1;
  localparam logic [2:0] REG_BEACON_LIMIT  = 3'd2;
  localparam logic [2:0] REG_WINDOW_LENGTH = 3'd3;
  localparam logic [2:0] REG_COOLDOWN      = 3'd4;
  localparam logic [2:0] REG_HOP_INTERVAL  = 3'd5;
  localparam logic [2:0] REG_FIRST_CHANNEL = 3'd6;

  localparam logic [15:0] RST_DEAUTH_LIMIT  = 16'd10;
  localparam logic [15:0] RST_PROBE_LIMIT   = 16'd50;
  localparam logic [15:0] RST_BEACON_LIMIT  = 16'd100;
  localparam logic [15:0] RST_WINDOW_LENGTH = 16'd1000;
  localparam logic [19:0] RST_COOLDOWN      = 20'd10000;
  localparam logic [15:0] RST_HOP_INTERVAL  = 16'd500;
  localparam logic [3:0]  RST_FIRST_CHANNEL = 4'd1;

  typedef struct packed {
    logic [15:0] deauth_limit;
    logic [15:0] probe_limit;
    logic [15:0] beacon_limit;
    logic [15:0] window_length;
    logic [19:0] cooldown_length;
    logic [15:0] hop_interval;
    logic [3:0]  first_channel;
  } cfg_t;

  typedef struct packed {
    logic [15:0] deauth;
    logic [15:0] probe;
    logic [15:0] beacon;
  } tally_t;

  function automatic logic [15:0] sat_inc16(logic [15:0] v);
    return (v != MAX16) ? v + 16'd1 : MAX16;
  endfunction

endpackage

// ----- hw/rtl/mfad_judge.sv -----
// Window evaluation: compares the tallies with their limits and picks the alert.
// Depends on mfad_pkg.
module mfad_judge (
  input  mfad_pkg::tally_t tally,
  input  mfad_pkg::cfg_t   cfg,
  input  mfad_pkg::alert_t alert,
  input  logic [19:0]      since_detection,
  output mfad_pkg::alert_t alert_next,
  output logic             detect
);

  logic       hit_d;
  logic       hit_b;
  logic       hit_p;
  logic [1:0] hits;

  assign hit_d  = tally.deauth >= cfg.deauth_limit;
  assign hit_b  = tally.beacon >= cfg.beacon_limit;
  assign hit_p  = tally.probe >= cfg.probe_limit;
  assign hits   = {1'b0, hit_d} + {1'b0, hit_b} + {1'b0, hit_p};
  assign detect = hits != 2'd0;

  always_comb begin
    priority if (hits >= 2'd2) begin
      alert_next = mfad_pkg::ALERT_MULTI;
    end else if (hit_d) begin
      alert_next = mfad_pkg::ALERT_DEAUTH;
    end else if (hit_b) begin
      alert_next = mfad_pkg::ALERT_BEACON;
    end else if (hit_p) begin
      alert_next = mfad_pkg::ALERT_PROBE;
    end else if (alert != mfad_pkg::ALERT_AMBIENT &&
                 since_detection >= cfg.cooldown_length) begin
      alert_next = mfad_pkg::ALERT_AMBIENT;
    end else begin
      alert_next = alert;
    end
  end

endmodule

// ----- hw/rtl/mgmt_frame_attack_detector.sv -----
// Management frame attack detector: one result per frame or tick transaction.
// A transaction passes the input register, then the result register, around
// combinational update logic; throughput 1 transaction/cycle while out_stall is low.
// Synchronous active-high reset: registers at reset values, tallies and timers
// cleared, alert ambient, channel from the first_channel reset value.
// Depends on mfad_pkg and mfad_judge.
module mgmt_frame_attack_detector #(
  parameter int unsigned CHANNEL_COUNT = mfad_pkg::CHANNEL_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic        is_management,
  input  logic [7:0]  frame_control,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  alert_state,
  output logic [3:0]  radio_channel,
  output logic        window_closed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  function automatic logic [3:0] legal_channel(logic [3:0] c);
    return (c == 4'd0 || 32'(c) > CHANNEL_COUNT) ? 4'd1 : c;
  endfunction

  // input register
  logic       s1_valid;
  logic       s1_opcode;
  logic       s1_mgmt;
  logic [7:0] s1_fc;

  mfad_pkg::cfg_t   cfg;
  mfad_pkg::tally_t tally, tally_next;
  logic [15:0]      window_elapsed, window_elapsed_next;
  logic [15:0]      hop_elapsed, hop_elapsed_next;
  logic [19:0]      since_detection, since_detection_next;
  mfad_pkg::alert_t current_alert, current_alert_next;
  logic [3:0]       current_channel, current_channel_next;
  logic             closed_next;

  logic             advance;
  logic             process;
  logic [15:0]      hop_inc;
  logic [15:0]      win_inc;
  logic [3:0]       sub;
  mfad_pkg::alert_t judged_alert;
  logic             detect;

  assign advance   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !advance;
  assign process   = s1_valid && advance;
  assign cfg_ready = 1'b1;
  assign sub       = s1_fc[7:4];
  assign hop_inc   = mfad_pkg::sat_inc16(hop_elapsed);
  assign win_inc   = mfad_pkg::sat_inc16(window_elapsed);

  mfad_judge u_judge (
    .tally           (tally),
    .cfg             (cfg),
    .alert           (current_alert),
    .since_detection (since_detection_next),
    .alert_next      (judged_alert),
    .detect          (detect)
  );

  always_comb begin
    tally_next           = tally;
    window_elapsed_next  = window_elapsed;
    hop_elapsed_next     = hop_elapsed;
    since_detection_next = since_detection;
    current_alert_next   = current_alert;
    current_channel_next = current_channel;
    closed_next          = 1'b0;
    if (s1_opcode == mfad_pkg::OP_FRAME) begin
      if (s1_mgmt && s1_fc[3:2] == mfad_pkg::TYPE_MGMT) begin
        priority if (sub == mfad_pkg::SUB_DEAUTH || sub == mfad_pkg::SUB_DISASSOC) begin
          tally_next.deauth = mfad_pkg::sat_inc16(tally.deauth);
        end else if (sub == mfad_pkg::SUB_PROBE) begin
          tally_next.probe = mfad_pkg::sat_inc16(tally.probe);
        end else if (sub == mfad_pkg::SUB_BEACON) begin
          tally_next.beacon = mfad_pkg::sat_inc16(tally.beacon);
        end else begin
          tally_next = tally;
        end
      end
    end else begin
      if (since_detection != mfad_pkg::MAX20) begin
        since_detection_next = since_detection + 20'd1;
      end
      hop_elapsed_next = hop_inc;
      if (hop_inc >= cfg.hop_interval) begin
        current_channel_next = (32'(current_channel) >= CHANNEL_COUNT) ?
                               4'd1 : current_channel + 4'd1;
        hop_elapsed_next     = 16'd0;
      end
      window_elapsed_next = win_inc;
      if (win_inc >= cfg.window_length) begin
        current_alert_next  = judged_alert;
        if (detect) begin
          since_detection_next = 20'd0;
        end
        tally_next          = '0;
        window_elapsed_next = 16'd0;
        closed_next         = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid              <= 1'b0;
      out_valid             <= 1'b0;
      cfg.deauth_limit      <= mfad_pkg::RST_DEAUTH_LIMIT;
      cfg.probe_limit       <= mfad_pkg::RST_PROBE_LIMIT;
      cfg.beacon_limit      <= mfad_pkg::RST_BEACON_LIMIT;
      cfg.window_length     <= mfad_pkg::RST_WINDOW_LENGTH;
      cfg.cooldown_length   <= mfad_pkg::RST_COOLDOWN;
      cfg.hop_interval      <= mfad_pkg::RST_HOP_INTERVAL;
      cfg.first_channel     <= mfad_pkg::RST_FIRST_CHANNEL;
      tally                 <= '0;
      window_elapsed        <= 16'd0;
      hop_elapsed           <= 16'd0;
      since_detection       <= 20'd0;
      current_alert         <= mfad_pkg::ALERT_AMBIENT;
      current_channel       <= legal_channel(mfad_pkg::RST_FIRST_CHANNEL);
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      if (process) begin
        tally           <= tally_next;
        window_elapsed  <= window_elapsed_next;
        hop_elapsed     <= hop_elapsed_next;
        since_detection <= since_detection_next;
        current_alert   <= current_alert_next;
        current_channel <= current_channel_next;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mfad_pkg::REG_DEAUTH_LIMIT:  cfg.deauth_limit    <= cfg_data[15:0];
          mfad_pkg::REG_PROBE_LIMIT:   cfg.probe_limit     <= cfg_data[15:0];
          mfad_pkg::REG_BEACON_LIMIT:  cfg.beacon_limit    <= cfg_data[15:0];
          mfad_pkg::REG_WINDOW_LENGTH: cfg.window_length   <= cfg_data[15:0];
          mfad_pkg::REG_COOLDOWN:      cfg.cooldown_length <= cfg_data;
          mfad_pkg::REG_HOP_INTERVAL:  cfg.hop_interval    <= cfg_data[15:0];
          mfad_pkg::REG_FIRST_CHANNEL: begin
            cfg.first_channel <= cfg_data[3:0];
            current_channel   <= legal_channel(cfg_data[3:0]);
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_opcode <= opcode;
      s1_mgmt   <= is_management;
      s1_fc     <= frame_control;
    end
    if (process) begin
      alert_state   <= 3'(current_alert_next);
      radio_channel <= current_channel_next;
      window_closed <= closed_next;
    end
  end

endmodule

// ----- hw/rtl/mfad_checker.sv -----
// Port-level checker for mgmt_frame_attack_detector, bound to the top level.
// Depends on mgmt_frame_attack_detector_macros.svh and mfad_pkg.
`include "mgmt_frame_attack_detector_macros.svh"

module mfad_checker #(
  parameter int unsigned CHANNEL_COUNT = mfad_pkg::CHANNEL_COUNT
) (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] alert_state,
  input logic [3:0] radio_channel,
  input logic       window_closed
);

  // held result keeps its payload
  `MFAD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(alert_state) && $stable(radio_channel) && $stable(window_closed))

  // input side backs up only when the result register is full and stalled
  `MFAD_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall)

  `MFAD_ASSERT_NOW(a_channel_range, out_valid, radio_channel != 4'd0 && 32'(radio_channel) <= CHANNEL_COUNT)

endmodule

bind mgmt_frame_attack_detector mfad_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_mfad_checker (
  .clk           (clk),
  .rst           (rst),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .alert_state   (alert_state),
  .radio_channel (radio_channel),
  .window_closed (window_closed)
);
